[rtl/i2c_mbe_pkg.sv]
package i2c_mbe_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

	// raw command codes on the mode field
	localparam logic [2:0] MODE_TICK = 3'd0;
	localparam logic [2:0] MODE_START = 3'd1;
	localparam logic [2:0] MODE_STOP = 3'd2;
	localparam logic [2:0] MODE_WRITE = 3'd3;
	localparam logic [2:0] MODE_WAIT = 3'd4;
	localparam logic [2:0] MODE_READ = 3'd5;

	typedef enum logic [5:0] {
		OP_IDLE  = 6'b000001,
		OP_START = 6'b000010,
		OP_STOP  = 6'b000100,
		OP_WRITE = 6'b001000,
		OP_WAIT  = 6'b010000,
		OP_READ  = 6'b100000
	} op_t;

	// classified tick word from the front to the back
	typedef struct packed {
		op_t cmd;
		logic [BITS_PER_BYTE-1:0] data_byte;
		logic send_ack;
		logic sda_sample;
	} tick_t;

	// result word from the back to the result queue
	typedef struct packed {
		logic scl_level;
		logic sda_level;
		logic busy_res;
		logic done_res;
		logic [BITS_PER_BYTE-1:0] read_data;
		logic ack_failed;
	} res_t;

	// mode field to command; unused codes mean tick only
	function automatic op_t decode_mode(input logic [2:0] mode);
		op_t op;
		op = OP_IDLE;
		case (mode)
			MODE_START: op = OP_START;
			MODE_STOP: op = OP_STOP;
			MODE_WRITE: op = OP_WRITE;
			MODE_WAIT: op = OP_WAIT;
			MODE_READ: op = OP_READ;
			default: op = OP_IDLE;
		endcase
		return op;
	endfunction

endpackage

[rtl/i2c_master_bit_engine_top.sv]
// i2c master bit engine: one input word per half-bit tick, one result word per tick
// a pushed word is registered in the input queue, its result in the result queue
// throughput: one word per cycle unless the result queue is full; the state is registered
// input and result queues (QUEUE_DEPTH words each) let either side stall on its own
// reset: queues empty, lines released high, sequencer idle, ack timeout 250
module i2c_master_bit_engine_top #(
	parameter int QUEUE_DEPTH = i2c_mbe_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  mode,
	input  logic [7:0]  data_byte,
	input  logic        send_ack,
	input  logic        sda_sample,
	input  logic        pop,
	output logic        empty,
	output logic        scl_level,
	output logic        sda_level,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  read_data,
	output logic        ack_failed
);

	localparam int RW = $bits(i2c_mbe_pkg::res_t);

	logic tick_valid;
	logic tick_take;
	i2c_mbe_pkg::tick_t tick;
	logic res_full;
	logic res_push;
	i2c_mbe_pkg::res_t res_in;
	logic [RW-1:0] res_bits;
	i2c_mbe_pkg::res_t res_out;

	// front: accept and classify
	i2c_mbe_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.mode(mode),
		.data_byte(data_byte),
		.send_ack(send_ack),
		.sda_sample(sda_sample),
		.tick_take(tick_take),
		.tick_valid(tick_valid),
		.tick(tick)
	);

	// back: line sequencer
	i2c_mbe_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.tick_valid(tick_valid),
		.tick(tick),
		.tick_take(tick_take),
		.res_full(res_full),
		.res_push(res_push),
		.res(res_in)
	);

	// result queue
	i2c_mbe_fifo #(
		.WIDTH(RW),
		.DEPTH(QUEUE_DEPTH)
	) u_res_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.full(res_full),
		.wdata(res_in),
		.pop(pop),
		.empty(empty),
		.rdata(res_bits)
	);

	assign res_out = i2c_mbe_pkg::res_t'(res_bits);
	assign scl_level = res_out.scl_level;
	assign sda_level = res_out.sda_level;
	assign busy_res = res_out.busy_res;
	assign done_res = res_out.done_res;
	assign read_data = res_out.read_data;
	assign ack_failed = res_out.ack_failed;

endmodule

[rtl/i2c_mbe_fifo.sv]
module i2c_mbe_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/i2c_mbe_front.sv]
module i2c_mbe_front #(
	parameter int DEPTH = i2c_mbe_pkg::QUEUE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [2:0]                          mode,
	input  logic [i2c_mbe_pkg::BITS_PER_BYTE-1:0] data_byte,
	input  logic                                send_ack,
	input  logic                                sda_sample,
	input  logic                                tick_take,
	output logic                                tick_valid,
	output i2c_mbe_pkg::tick_t                  tick
);

	localparam int TW = $bits(i2c_mbe_pkg::tick_t);

	i2c_mbe_pkg::tick_t in_word;
	logic [TW-1:0] out_bits;
	logic q_empty;

	// classify the mode field at the door
	always_comb begin
		in_word.cmd = i2c_mbe_pkg::decode_mode(mode);
		in_word.data_byte = data_byte;
		in_word.send_ack = send_ack;
		in_word.sda_sample = sda_sample;
	end

	i2c_mbe_fifo #(
		.WIDTH(TW),
		.DEPTH(DEPTH)
	) u_tick_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.wdata(in_word),
		.pop(tick_take),
		.empty(q_empty),
		.rdata(out_bits)
	);

	assign tick_valid = !q_empty;
	assign tick = i2c_mbe_pkg::tick_t'(out_bits);

endmodule

[rtl/i2c_mbe_back.sv]
module i2c_mbe_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [7:0]                            cfg_wdata,
	input  logic                                  tick_valid,
	input  i2c_mbe_pkg::tick_t                    tick,
	output logic                                  tick_take,
	input  logic                                  res_full,
	output logic                                  res_push,
	output i2c_mbe_pkg::res_t                     res
);

	localparam int BPB = i2c_mbe_pkg::BITS_PER_BYTE;
	localparam logic [4:0] NBITS2 = 5'(2 * BPB);

	logic [7:0] ack_timeout_q;
	i2c_mbe_pkg::op_t op_q, op_d;
	logic [4:0] step_q, step_d;
	logic [BPB-1:0] shift_q, shift_d;
	logic [7:0] wait_q, wait_d;
	logic scl_q, scl_d;
	logic sda_q, sda_d;
	logic fail_q, fail_d;
	logic ack_q, ack_d;
	logic [BPB-1:0] rd_hold_q, rd_hold_d;
	logic done;

	assign tick_take = tick_valid && !res_full;
	assign res_push = tick_take;

	// one tick of the line sequencer
	always_comb begin
		logic [4:0] s;
		logic [8:0] wait_next;
		logic post_scl_low;
		logic post_sda_high;
		logic scl_out;
		logic sda_out;

		op_d = op_q;
		step_d = step_q;
		shift_d = shift_q;
		wait_d = wait_q;
		scl_d = scl_q;
		sda_d = sda_q;
		fail_d = fail_q;
		ack_d = ack_q;
		rd_hold_d = rd_hold_q;
		done = 1'b0;
		post_scl_low = 1'b0;
		post_sda_high = 1'b0;
		wait_next = {1'b0, wait_q} + 9'd1;

		// command launch while idle
		if (op_q == i2c_mbe_pkg::OP_IDLE && tick.cmd != i2c_mbe_pkg::OP_IDLE) begin
			op_d = tick.cmd;
			step_d = '0;
			if (tick.cmd == i2c_mbe_pkg::OP_WRITE) begin
				shift_d = tick.data_byte;
			end
			if (tick.cmd == i2c_mbe_pkg::OP_READ) begin
				shift_d = '0;
				ack_d = tick.send_ack;
			end
			if (tick.cmd == i2c_mbe_pkg::OP_WAIT) begin
				wait_d = '0;
			end
		end
		s = step_d;
		wait_next = {1'b0, wait_d} + 9'd1;

		// line changes ahead of the delay
		case (op_d)
			i2c_mbe_pkg::OP_START: begin
				if (s == 5'd0) begin
					sda_d = 1'b1;
					scl_d = 1'b1;
				end else if (s == 5'd1) begin
					sda_d = 1'b0;
				end else begin
					scl_d = 1'b0;
					done = 1'b1;
				end
			end
			i2c_mbe_pkg::OP_STOP: begin
				if (s == 5'd0) begin
					sda_d = 1'b0;
				end else if (s == 5'd1) begin
					scl_d = 1'b1;
				end else begin
					sda_d = 1'b1;
					done = 1'b1;
				end
			end
			i2c_mbe_pkg::OP_WRITE: begin
				if (!s[0]) begin
					sda_d = shift_d[BPB-1];
				end else begin
					scl_d = 1'b1;
					post_scl_low = 1'b1;
					if (s >= NBITS2 - 5'd1) begin
						post_sda_high = 1'b1;
						done = 1'b1;
					end
				end
			end
			i2c_mbe_pkg::OP_WAIT: begin
				if (s == 5'd0) begin
					sda_d = 1'b1;
				end else if (s == 5'd1) begin
					scl_d = 1'b1;
				end else if (s == 5'd2) begin
					if (!tick.sda_sample) begin
						scl_d = 1'b0;
						fail_d = 1'b0;
						done = 1'b1;
					end else begin
						wait_d = wait_next[7:0];
						if (wait_next > {1'b0, ack_timeout_q}) begin
							sda_d = 1'b0;
							step_d = 5'd3;
						end
					end
				end else if (s == 5'd4) begin
					scl_d = 1'b1;
				end else if (s == 5'd5) begin
					sda_d = 1'b1;
				end else if (s >= 5'd6) begin
					scl_d = 1'b0;
					fail_d = 1'b1;
					done = 1'b1;
				end
			end
			i2c_mbe_pkg::OP_READ: begin
				if (s < NBITS2) begin
					scl_d = !s[0];
				end else begin
					case (s[1:0])
						2'd0: sda_d = !ack_d;
						2'd1: scl_d = 1'b1;
						2'd2: begin
							scl_d = 1'b0;
							if (!ack_d) begin
								done = 1'b1;
							end
						end
						default: begin
							sda_d = 1'b1;
							done = 1'b1;
						end
					endcase
				end
			end
			default: begin
			end
		endcase

		scl_out = scl_d;
		sda_out = sda_d;

		// changes after the delay, seen from the next tick
		if (op_d == i2c_mbe_pkg::OP_READ && s < NBITS2 && !s[0]) begin
			shift_d = {shift_d[BPB-2:0], tick.sda_sample};
		end
		if (op_d == i2c_mbe_pkg::OP_WRITE && post_scl_low) begin
			shift_d = {shift_d[BPB-2:0], 1'b0};
		end
		if (post_scl_low) begin
			scl_d = 1'b0;
		end
		if (post_sda_high) begin
			sda_d = 1'b1;
		end

		// finish or advance
		if (done) begin
			if (op_d == i2c_mbe_pkg::OP_READ) begin
				rd_hold_d = shift_d;
			end
			op_d = i2c_mbe_pkg::OP_IDLE;
			step_d = '0;
		end else if (op_d != i2c_mbe_pkg::OP_IDLE) begin
			if (!(op_d == i2c_mbe_pkg::OP_WAIT && s == 5'd2 && step_d == 5'd2)) begin
				step_d = step_d + 5'd1;
			end
		end

		res.scl_level = scl_out;
		res.sda_level = sda_out;
		res.busy_res = (op_d != i2c_mbe_pkg::OP_IDLE);
		res.done_res = done;
		res.read_data = rd_hold_d;
		res.ack_failed = fail_d;
	end

	// sequencer state and timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_timeout_q <= i2c_mbe_pkg::ACK_TIMEOUT_RST;
			op_q <= i2c_mbe_pkg::OP_IDLE;
			step_q <= '0;
			shift_q <= '0;
			wait_q <= '0;
			scl_q <= 1'b1;
			sda_q <= 1'b1;
			fail_q <= 1'b0;
			ack_q <= 1'b0;
			rd_hold_q <= '0;
		end else begin
			if (cfg_we) begin
				ack_timeout_q <= cfg_wdata;
			end
			if (tick_take) begin
				op_q <= op_d;
				step_q <= step_d;
				shift_q <= shift_d;
				wait_q <= wait_d;
				scl_q <= scl_d;
				sda_q <= sda_d;
				fail_q <= fail_d;
				ack_q <= ack_d;
				rd_hold_q <= rd_hold_d;
			end
		end
	end

endmodule

[verif/i2c_master_bit_engine_top_test.sv]
`timescale 1ns / 1ps

module i2c_master_bit_engine_top_test;

	localparam int MAX_CYCLES = 400000;
	localparam int MAX_REPORTS = 10;
	localparam int PHASE_TICKS = 90;
	// mode codes with no command behind them
	localparam logic [2:0] MODE_SPARE_6 = 3'd6;
	localparam logic [2:0] MODE_SPARE_7 = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'd0;
	logic push = 1'b0;
	logic full;
	logic [2:0] mode = i2c_mbe_pkg::MODE_TICK;
	logic [7:0] data_byte = 8'd0;
	logic send_ack = 1'b0;
	logic sda_sample = 1'b1;
	logic pop = 1'b0;
	logic empty;
	logic scl_level;
	logic sda_level;
	logic busy_res;
	logic done_res;
	logic [7:0] read_data;
	logic ack_failed;

	// line sequencer mirror
	i2c_mbe_pkg::op_t seq_op;
	logic [4:0] seq_step;
	logic [7:0] seq_shift;
	logic [7:0] seq_wait;
	logic [7:0] seq_timeout;
	logic [7:0] seq_rd;
	logic seq_scl;
	logic seq_sda;
	logic seq_fail;
	logic seq_ackc;

	i2c_mbe_pkg::res_t pending_ticks[$];
	bit gaps_on = 1'b1;
	int ticks_sent = 0;
	int words_checked = 0;
	int mismatches = 0;
	int settings_used = 0;
	int timeouts_seen = 0;
	int cycles = 0;

	i2c_master_bit_engine_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.push(push),
		.full(full),
		.mode(mode),
		.data_byte(data_byte),
		.send_ack(send_ack),
		.sda_sample(sda_sample),
		.pop(pop),
		.empty(empty),
		.scl_level(scl_level),
		.sda_level(sda_level),
		.busy_res(busy_res),
		.done_res(done_res),
		.read_data(read_data),
		.ack_failed(ack_failed)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= MAX_CYCLES) begin
			$display("run limit of %0d cycles reached", MAX_CYCLES);
			$display("[i2c_master_bit_engine_top] ERROR");
			$finish;
		end
	end

	// sequencer state after reset
	task automatic reset_line_model();
		seq_op = i2c_mbe_pkg::OP_IDLE;
		seq_step = '0;
		seq_shift = '0;
		seq_wait = '0;
		seq_timeout = i2c_mbe_pkg::ACK_TIMEOUT_RST;
		seq_rd = '0;
		seq_scl = 1'b1;
		seq_sda = 1'b1;
		seq_fail = 1'b0;
		seq_ackc = 1'b0;
	endtask

	// one half-bit tick of the line sequencer
	function automatic i2c_mbe_pkg::res_t compute_line_tick(input logic [2:0] m,
			input logic [7:0] db, input logic sa, input logic sd);
		i2c_mbe_pkg::res_t r;
		int s;
		int rs;
		logic [8:0] polls;
		logic fin;
		logic scl_drop;
		logic sda_rel;
		fin = 1'b0;
		scl_drop = 1'b0;
		sda_rel = 1'b0;

		// command start, only while idle
		if (seq_op == i2c_mbe_pkg::OP_IDLE) begin
			case (m)
				i2c_mbe_pkg::MODE_START: seq_op = i2c_mbe_pkg::OP_START;
				i2c_mbe_pkg::MODE_STOP: seq_op = i2c_mbe_pkg::OP_STOP;
				i2c_mbe_pkg::MODE_WRITE: seq_op = i2c_mbe_pkg::OP_WRITE;
				i2c_mbe_pkg::MODE_WAIT: seq_op = i2c_mbe_pkg::OP_WAIT;
				i2c_mbe_pkg::MODE_READ: seq_op = i2c_mbe_pkg::OP_READ;
				default: seq_op = i2c_mbe_pkg::OP_IDLE;
			endcase
			if (seq_op != i2c_mbe_pkg::OP_IDLE) begin
				seq_step = '0;
				if (seq_op == i2c_mbe_pkg::OP_WRITE)
					seq_shift = db;
				if (seq_op == i2c_mbe_pkg::OP_READ) begin
					seq_shift = '0;
					seq_ackc = sa;
				end
				if (seq_op == i2c_mbe_pkg::OP_WAIT)
					seq_wait = '0;
			end
		end

		s = int'(seq_step);
		case (seq_op)
			i2c_mbe_pkg::OP_START: begin
				if (s == 0) begin
					seq_sda = 1'b1;
					seq_scl = 1'b1;
				end else if (s == 1) begin
					seq_sda = 1'b0;
				end else begin
					seq_scl = 1'b0;
					fin = 1'b1;
				end
			end
			i2c_mbe_pkg::OP_STOP: begin
				if (s == 0) begin
					seq_sda = 1'b0;
				end else if (s == 1) begin
					seq_scl = 1'b1;
				end else begin
					seq_sda = 1'b1;
					fin = 1'b1;
				end
			end
			i2c_mbe_pkg::OP_WRITE: begin
				if (s % 2 == 0) begin
					seq_sda = seq_shift[i2c_mbe_pkg::BITS_PER_BYTE-1];
				end else begin
					seq_scl = 1'b1;
					scl_drop = 1'b1;
					if (s + 1 >= 2 * i2c_mbe_pkg::BITS_PER_BYTE) begin
						sda_rel = 1'b1;
						fin = 1'b1;
					end
				end
			end
			i2c_mbe_pkg::OP_WAIT: begin
				if (s == 0) begin
					seq_sda = 1'b1;
				end else if (s == 1) begin
					seq_scl = 1'b1;
				end else if (s == 2) begin
					if (!sd) begin
						seq_scl = 1'b0;
						seq_fail = 1'b0;
						fin = 1'b1;
					end else begin
						// compare one bit wider so a limit of 255 never wraps
						polls = {1'b0, seq_wait} + 9'd1;
						seq_wait = polls[7:0];
						if (polls > {1'b0, seq_timeout}) begin
							seq_sda = 1'b0;
							seq_step = 5'd3;
						end
					end
				end else if (s == 4) begin
					seq_scl = 1'b1;
				end else if (s == 5) begin
					seq_sda = 1'b1;
				end else if (s >= 6) begin
					seq_scl = 1'b0;
					seq_fail = 1'b1;
					fin = 1'b1;
					timeouts_seen++;
				end
			end
			i2c_mbe_pkg::OP_READ: begin
				if (s < 2 * i2c_mbe_pkg::BITS_PER_BYTE) begin
					seq_scl = (s % 2 == 0);
				end else begin
					rs = s - 2 * i2c_mbe_pkg::BITS_PER_BYTE;
					if (rs == 0) begin
						seq_sda = !seq_ackc;
					end else if (rs == 1) begin
						seq_scl = 1'b1;
					end else if (rs == 2) begin
						seq_scl = 1'b0;
						if (!seq_ackc)
							fin = 1'b1;
					end else begin
						seq_sda = 1'b1;
						fin = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		r.scl_level = seq_scl;
		r.sda_level = seq_sda;

		// changes that show from the next tick
		if (seq_op == i2c_mbe_pkg::OP_READ && s < 2 * i2c_mbe_pkg::BITS_PER_BYTE && s % 2 == 0)
			seq_shift = {seq_shift[i2c_mbe_pkg::BITS_PER_BYTE-2:0], sd};
		if (seq_op == i2c_mbe_pkg::OP_WRITE && scl_drop)
			seq_shift = {seq_shift[i2c_mbe_pkg::BITS_PER_BYTE-2:0], 1'b0};
		if (scl_drop)
			seq_scl = 1'b0;
		if (sda_rel)
			seq_sda = 1'b1;

		if (fin) begin
			if (seq_op == i2c_mbe_pkg::OP_READ)
				seq_rd = seq_shift;
			seq_op = i2c_mbe_pkg::OP_IDLE;
			seq_step = '0;
		end else if (seq_op != i2c_mbe_pkg::OP_IDLE) begin
			// the poll step holds until ack or timeout
			if (!(seq_op == i2c_mbe_pkg::OP_WAIT && s == 2 && seq_step == 5'd2))
				seq_step = seq_step + 5'd1;
		end

		r.busy_res = (seq_op != i2c_mbe_pkg::OP_IDLE);
		r.done_res = fin;
		r.read_data = seq_rd;
		r.ack_failed = seq_fail;
		return r;
	endfunction

	task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("word %0d %s: expected %0h, got %0h", words_checked, field, want, got);
		end
	endtask

	// send one input word, after a random idle gap
	task automatic send_tick(input logic [2:0] m, input logic [7:0] db, input logic sa,
			input logic sd);
		int gap;
		gap = gaps_on ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		mode <= m;
		data_byte <= db;
		send_ack <= sa;
		sda_sample <= sd;
		do @(posedge clk); while (full);
		pending_ticks.push_back(compute_line_tick(m, db, sa, sd));
		ticks_sent++;
	endtask

	// one command and the ticks that carry it to its end; ack_delay is the
	// number of high polls before the slave pulls sda low
	task automatic run_cmd(input logic [2:0] m, input logic [7:0] db, input logic sa,
			input int ack_delay);
		int k;
		logic sd;
		logic [2:0] cmd;
		k = 0;
		do begin
			if (m == i2c_mbe_pkg::MODE_WAIT)
				sd = (k < 2 + ack_delay) ? 1'b1 : 1'b0;
			else
				sd = 1'($urandom_range(0, 1));
			// filler ticks now and then carry a command that must be ignored
			if (k == 0)
				cmd = m;
			else if ($urandom_range(0, 9) < 6)
				cmd = i2c_mbe_pkg::MODE_TICK;
			else
				cmd = 3'($urandom_range(0, 7));
			if (k == 0)
				send_tick(cmd, db, sa, sd);
			else
				send_tick(cmd, 8'($urandom), 1'($urandom_range(0, 1)), sd);
			k++;
		end while (seq_op != i2c_mbe_pkg::OP_IDLE);
	endtask

	// hold the sender until every expected word has come back
	task automatic wait_drained();
		push <= 1'b0;
		do @(posedge clk); while (pending_ticks.size() != 0);
	endtask

	task automatic set_timeout(input logic [7:0] value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		seq_timeout = value;
		settings_used++;
	endtask

	// reset outputs and codes without a command
	task automatic test_idle_ticks();
		send_tick(i2c_mbe_pkg::MODE_TICK, 8'hFF, 1'b1, 1'b1);
		send_tick(MODE_SPARE_6, 8'h00, 1'b0, 1'b0);
		send_tick(MODE_SPARE_7, 8'hFF, 1'b1, 1'b0);
		send_tick(i2c_mbe_pkg::MODE_TICK, 8'h00, 1'b0, 1'b1);
	endtask

	// every command at least once at the reset timeout
	task automatic test_each_command();
		run_cmd(i2c_mbe_pkg::MODE_START, 8'h00, 1'b0, 0);
		run_cmd(i2c_mbe_pkg::MODE_WRITE, 8'h00, 1'b0, 0);
		run_cmd(i2c_mbe_pkg::MODE_WRITE, 8'hFF, 1'b1, 0);
		run_cmd(i2c_mbe_pkg::MODE_WRITE, 8'hA5, 1'b0, 0);
		run_cmd(i2c_mbe_pkg::MODE_WAIT, 8'h00, 1'b0, 0);
		run_cmd(i2c_mbe_pkg::MODE_WAIT, 8'hFF, 1'b1, 3);
		run_cmd(i2c_mbe_pkg::MODE_READ, 8'hFF, 1'b1, 0);
		run_cmd(i2c_mbe_pkg::MODE_READ, 8'h00, 1'b0, 0);
		run_cmd(i2c_mbe_pkg::MODE_STOP, 8'h00, 1'b0, 0);
	endtask

	// ack wait at the edges of the timeout range
	task automatic test_timeout_bounds();
		set_timeout(8'd0);
		run_cmd(i2c_mbe_pkg::MODE_WAIT, 8'h00, 1'b0, 0);
		run_cmd(i2c_mbe_pkg::MODE_WAIT, 8'h00, 1'b0, 1);
		set_timeout(8'd1);
		run_cmd(i2c_mbe_pkg::MODE_WAIT, 8'h00, 1'b0, 1);
		run_cmd(i2c_mbe_pkg::MODE_WAIT, 8'h00, 1'b0, 2);
		set_timeout(8'd255);
		run_cmd(i2c_mbe_pkg::MODE_WAIT, 8'h00, 1'b0, 256);
	endtask

	// random commands in phases with different timeouts
	task automatic test_random_traffic();
		logic [7:0] setting;
		int phase;
		int stop_at;
		int pick;
		int delay;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: setting = 8'($urandom_range(1, 6));
				1: setting = i2c_mbe_pkg::ACK_TIMEOUT_RST;
				2: setting = 8'($urandom_range(0, 255));
				default: setting = 8'd1;
			endcase
			set_timeout(setting);
			gaps_on = (phase != 3);
			stop_at = ticks_sent + PHASE_TICKS;
			while (ticks_sent < stop_at) begin
				pick = $urandom_range(0, 19);
				if (seq_timeout <= 8)
					delay = $urandom_range(0, int'(seq_timeout) + 2);
				else
					delay = $urandom_range(0, 3);
				if (pick == 0)
					run_cmd(i2c_mbe_pkg::MODE_TICK, 8'($urandom), 1'($urandom_range(0, 1)), 0);
				else if (pick == 1)
					run_cmd(($urandom_range(0, 1) != 0) ? MODE_SPARE_6 : MODE_SPARE_7,
						8'($urandom), 1'($urandom_range(0, 1)), 0);
				else
					run_cmd(3'($urandom_range(1, 5)), 8'($urandom),
						1'($urandom_range(0, 1)), delay);
				if ($urandom_range(0, 29) == 0)
					wait_drained();
			end
		end
		gaps_on = 1'b1;
	endtask

	// result side: random pop stalls, each word checked against the oldest expectation
	initial begin : result_side
		int stall;
		i2c_mbe_pkg::res_t want;
		wait (arst_n);
		forever begin
			stall = gaps_on ? $urandom_range(0, 7) : 0;
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			if (pending_ticks.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("word %0d arrived with nothing expected", words_checked);
			end else begin
				want = pending_ticks.pop_front();
				check_field("scl_level", 8'(want.scl_level), 8'(scl_level));
				check_field("sda_level", 8'(want.sda_level), 8'(sda_level));
				check_field("busy_res", 8'(want.busy_res), 8'(busy_res));
				check_field("done_res", 8'(want.done_res), 8'(done_res));
				check_field("read_data", want.read_data, read_data);
				check_field("ack_failed", 8'(want.ack_failed), 8'(ack_failed));
			end
			words_checked++;
		end
	end

	// test sequence
	initial begin
		reset_line_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_idle_ticks();
		test_each_command();
		test_timeout_bounds();
		test_random_traffic();
		wait_drained();
		repeat (4) @(posedge clk);
		if (pending_ticks.size() != 0) begin
			mismatches++;
			$display("%0d expected words never arrived", pending_ticks.size());
		end
		$display("ran %0d ticks through start, stop, write, ack wait and read commands",
			ticks_sent);
		$display("%0d words checked over %0d timeout settings, %0d ack timeouts, %0d mismatches",
			words_checked, settings_used, timeouts_seen, mismatches);
		if (mismatches == 0) begin
			$display("[i2c_master_bit_engine_top] OK");
		end else begin
			$display("[i2c_master_bit_engine_top] ERROR");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/i2c_mbe_pkg.sv
rtl/i2c_mbe_fifo.sv
rtl/i2c_mbe_front.sv
rtl/i2c_mbe_back.sv
rtl/i2c_master_bit_engine_top.sv
verif/i2c_master_bit_engine_top_test.sv
